// ===== hw/rtl/smalu_pkg.sv =====
// shared types and constants for the stack machine alu
// no dependencies
package smalu_pkg;
	localparam int StackDepth = 128;
	localparam int AddrW = $clog2(StackDepth);
	localparam int DepthW = $clog2(StackDepth + 1);
	localparam int DataW = 64;

	localparam logic [4:0] CMD_PUSH = 5'd0;
	localparam logic [4:0] CMD_DROP = 5'd1;
	localparam logic [4:0] CMD_DUP  = 5'd2;
	localparam logic [4:0] CMD_SWAP = 5'd3;
	localparam logic [4:0] CMD_OVER = 5'd4;
	localparam logic [4:0] CMD_ROT  = 5'd5;
	localparam logic [4:0] CMD_ADD  = 5'd6;
	localparam logic [4:0] CMD_SUB  = 5'd7;
	localparam logic [4:0] CMD_MUL  = 5'd8;
	localparam logic [4:0] CMD_DIV  = 5'd9;
	localparam logic [4:0] CMD_MOD  = 5'd10;
	localparam logic [4:0] CMD_EQ   = 5'd11;
	localparam logic [4:0] CMD_GT   = 5'd12;
	localparam logic [4:0] CMD_LT   = 5'd13;
	localparam logic [4:0] CMD_AND  = 5'd14;
	localparam logic [4:0] CMD_OR   = 5'd15;
	localparam logic [4:0] CMD_XOR  = 5'd16;
	localparam logic [4:0] CMD_NOT  = 5'd17;

	localparam logic [1:0] FLT_NONE  = 2'd0;
	localparam logic [1:0] FLT_UNDER = 2'd1;
	localparam logic [1:0] FLT_OVER  = 2'd2;
	localparam logic [1:0] FLT_DIVZ  = 2'd3;

	typedef struct packed {
		logic [4:0]        cmd;
		logic signed [63:0] literal;
	} smalu_req_t;

	typedef struct packed {
		logic signed [63:0] top_value;
		logic [7:0]         stack_depth;
		logic [1:0]         fault;
	} smalu_rsp_t;
endpackage

// ===== hw/rtl/smalu_if.sv =====
// valid/ready channel carrying one payload
// no dependencies
interface smalu_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/smalu_ram.sv =====
// generic single-port-write, one-read synchronous ram, registered read
// no dependencies
module smalu_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/smalu_div.sv =====
// iterative signed divider, one quotient bit per cycle
// depends on smalu_pkg
module smalu_div
	import smalu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DataW-1:0] a,
	input  logic [DataW-1:0] b,
	output logic             done,
	output logic [DataW-1:0] quo,
	output logic [DataW-1:0] rem
);
	logic [DataW-1:0] q_q, r_q, d_q;
	logic [6:0] cnt_q;
	logic busy_q, qneg_q, rneg_q;
	logic [DataW:0] trial;
	logic [DataW-1:0] rsh;

	assign rsh = {r_q[DataW-2:0], q_q[DataW-1]};
	assign trial = {r_q, q_q[DataW-1]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'(DataW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= a[DataW-1] ? -a : a;
			d_q <= b[DataW-1] ? -b : b;
			r_q <= '0;
			qneg_q <= a[DataW-1] ^ b[DataW-1];
			rneg_q <= a[DataW-1];
		end else if (busy_q) begin
			if (!trial[DataW]) begin
				r_q <= trial[DataW-1:0];
				q_q <= {q_q[DataW-2:0], 1'b1};
			end else begin
				r_q <= rsh;
				q_q <= {q_q[DataW-2:0], 1'b0};
			end
		end
	end

	assign quo = qneg_q ? -q_q : q_q;
	assign rem = rneg_q ? -r_q : r_q;
endmodule

// ===== hw/rtl/stack_machine_alu_unit.sv =====
// stack machine alu: forth-style data stack with integer alu
// per request: one ram read per entry touched, one write per entry, 64-step divider
// requests: one at a time; the next request can be taken in the cycle after the response
// reset: depth and control clear at once; stack ram contents stay undefined
module stack_machine_alu_unit
	import smalu_pkg::*;
(
	input logic clk,
	input logic arst_n,
	smalu_if.sink   req,
	smalu_if.source rsp
);
	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_RD1   = 10'b0000000010,
		ST_RD2   = 10'b0000000100,
		ST_RD3   = 10'b0000001000,
		ST_EXEC  = 10'b0000010000,
		ST_MUL   = 10'b0000100000,
		ST_DIVW  = 10'b0001000000,
		ST_WR    = 10'b0010000000,
		ST_TOP   = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [DepthW-1:0] depth_q;
	logic [4:0] cmd_q;
	logic [DataW-1:0] e1_q, e2_q, e3_q, res_q;
	logic [1:0] fault_q, need, nreads_q;
	logic room;
	// write queue: up to three entries written one per cycle
	logic [DataW-1:0] wd_q [3];
	logic [AddrW-1:0] wa_q [3];
	logic [1:0] wn_q, wi_q;
	logic [DepthW-1:0] nd_q;
	logic [DataW-1:0] top_q;
	logic top_known_q;
	logic [DataW-1:0] pl_s1;
	logic [31:0] pp1_s1, pp2_s1;
	logic [1:0] mstep_q;

	logic we;
	logic [AddrW-1:0] waddr, raddr;
	logic [DataW-1:0] wdata, rdata;
	logic div_start, div_done;
	logic [DataW-1:0] quo, rem;

	smalu_ram #(.Width(DataW), .Depth(StackDepth)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	smalu_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .a(e2_q), .b(e1_q),
		.done(div_done), .quo(quo), .rem(rem)
	);

	// operand count needed by each command, and whether it needs a free slot
	always_comb begin
		need = 2'd0;
		room = 1'b0;
		case (req.data.cmd) inside
			CMD_PUSH: room = 1'b1;
			CMD_DROP, CMD_NOT: need = 2'd1;
			CMD_DUP: begin need = 2'd1; room = 1'b1; end
			CMD_OVER: begin need = 2'd2; room = 1'b1; end
			CMD_ROT: need = 2'd3;
			CMD_SWAP, [CMD_ADD:CMD_XOR]: need = 2'd2;
			default: need = 2'd0;
		endcase
	end

	// reads go top first: e1 = top, e2 = second, e3 = third
	logic [DepthW-1:0] rd_off;
	always_comb begin
		rd_off = '0;
		case (state_q)
			ST_RD1: rd_off = DepthW'(2);
			ST_RD2: rd_off = DepthW'(3);
			default: rd_off = DepthW'(1);
		endcase
	end
	assign raddr = AddrW'(depth_q - rd_off);
	assign we = (state_q == ST_WR) && (wi_q != wn_q);
	assign waddr = wa_q[wi_q];
	assign wdata = wd_q[wi_q];
	assign div_start = (state_q == ST_EXEC) && (cmd_q == CMD_DIV || cmd_q == CMD_MOD)
		&& (e1_q != '0);

	logic nz1, nz2;
	assign nz1 = e1_q != '0;
	assign nz2 = e2_q != '0;

	// combinational alu for add, sub, compares and logic words
	logic [DataW-1:0] alu_res;
	always_comb begin
		case (cmd_q)
			CMD_ADD: alu_res = e2_q + e1_q;
			CMD_SUB: alu_res = e2_q - e1_q;
			CMD_EQ:  alu_res = DataW'(e2_q == e1_q);
			CMD_GT:  alu_res = DataW'($signed(e2_q) > $signed(e1_q));
			CMD_LT:  alu_res = DataW'($signed(e2_q) < $signed(e1_q));
			CMD_AND: alu_res = DataW'(nz1 && nz2);
			CMD_OR:  alu_res = DataW'(nz1 || nz2);
			CMD_XOR: alu_res = DataW'(nz1 ^ nz2);
			default: alu_res = '0;
		endcase
	end

	logic [DepthW-1:0] d2;
	assign d2 = depth_q - DepthW'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			depth_q <= '0;
			wn_q <= '0;
			wi_q <= '0;
			mstep_q <= '0;
			top_known_q <= 1'b0;
			nd_q <= '0;
			fault_q <= FLT_NONE;
			nreads_q <= '0;
			top_q <= '0;
			wa_q <= '{default: '0};
			wd_q <= '{default: '0};
		end else begin
			case (state_q)
				ST_IDLE: if (req.valid) begin
					wn_q <= '0;
					wi_q <= '0;
					top_known_q <= 1'b0;
					nd_q <= depth_q;
					if (DepthW'(need) > depth_q) begin
						fault_q <= FLT_UNDER;
						state_q <= ST_TOP;
					end else if (room && depth_q == DepthW'(StackDepth)) begin
						fault_q <= FLT_OVER;
						state_q <= ST_TOP;
					end else begin
						fault_q <= FLT_NONE;
						if (req.data.cmd == CMD_PUSH) begin
							wa_q[0] <= AddrW'(depth_q);
							wd_q[0] <= req.data.literal;
							wn_q <= 2'd1;
							nd_q <= depth_q + DepthW'(1);
							top_q <= req.data.literal;
							top_known_q <= 1'b1;
							state_q <= ST_WR;
						end else if (req.data.cmd == CMD_DROP) begin
							nd_q <= depth_q - DepthW'(1);
							state_q <= ST_TOP;
						end else if (need == 2'd0) begin
							state_q <= ST_TOP;
						end else begin
							nreads_q <= need;
							state_q <= ST_RD1;
						end
					end
				end
				ST_RD1: state_q <= (nreads_q == 2'd1) ? ST_EXEC : ST_RD2;
				ST_RD2: state_q <= (nreads_q == 2'd2) ? ST_EXEC : ST_RD3;
				ST_RD3: state_q <= ST_EXEC;
				ST_EXEC: begin
					top_known_q <= 1'b1;
					state_q <= ST_WR;
					case (cmd_q) inside
						CMD_DUP: begin
							wa_q[0] <= AddrW'(depth_q); wd_q[0] <= e1_q; wn_q <= 2'd1;
							nd_q <= depth_q + DepthW'(1); top_q <= e1_q;
						end
						CMD_OVER: begin
							wa_q[0] <= AddrW'(depth_q); wd_q[0] <= e2_q; wn_q <= 2'd1;
							nd_q <= depth_q + DepthW'(1); top_q <= e2_q;
						end
						CMD_SWAP: begin
							wa_q[0] <= AddrW'(depth_q - DepthW'(1)); wd_q[0] <= e2_q;
							wa_q[1] <= AddrW'(d2); wd_q[1] <= e1_q;
							wn_q <= 2'd2; top_q <= e2_q;
						end
						CMD_ROT: begin
							wa_q[0] <= AddrW'(depth_q - DepthW'(1)); wd_q[0] <= e3_q;
							wa_q[1] <= AddrW'(d2); wd_q[1] <= e1_q;
							wa_q[2] <= AddrW'(depth_q - DepthW'(3)); wd_q[2] <= e2_q;
							wn_q <= 2'd3; top_q <= e3_q;
						end
						CMD_NOT: begin
							wa_q[0] <= AddrW'(depth_q - DepthW'(1));
							wd_q[0] <= DataW'(!nz1); wn_q <= 2'd1; top_q <= DataW'(!nz1);
						end
						CMD_MUL: begin
							mstep_q <= '0;
							top_known_q <= 1'b0;
							state_q <= ST_MUL;
						end
						CMD_DIV, CMD_MOD: begin
							top_known_q <= 1'b0;
							if (!nz1) begin
								fault_q <= FLT_DIVZ;
								nd_q <= d2;
								state_q <= ST_TOP;
							end else begin
								state_q <= ST_DIVW;
							end
						end
						default: begin
							wa_q[0] <= AddrW'(d2); wd_q[0] <= alu_res; wn_q <= 2'd1;
							nd_q <= depth_q - DepthW'(1); top_q <= alu_res;
						end
					endcase
				end
				ST_MUL: begin
					mstep_q <= mstep_q + 2'd1;
					if (mstep_q == 2'd1) begin
						wa_q[0] <= AddrW'(d2); wd_q[0] <= res_q; wn_q <= 2'd1;
						nd_q <= depth_q - DepthW'(1); top_q <= res_q;
						top_known_q <= 1'b1;
						state_q <= ST_WR;
					end
				end
				ST_DIVW: if (div_done) begin
					wa_q[0] <= AddrW'(d2); wn_q <= 2'd1;
					wd_q[0] <= (cmd_q == CMD_DIV) ? quo : rem;
					top_q <= (cmd_q == CMD_DIV) ? quo : rem;
					top_known_q <= 1'b1;
					nd_q <= depth_q - DepthW'(1);
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (wi_q != wn_q) begin
						wi_q <= wi_q + 2'd1;
					end else begin
						depth_q <= nd_q;
						state_q <= top_known_q ? ST_OUT : ST_TOP;
					end
				end
				ST_TOP: begin
					// first pass commits the depth, second pass reads the new top
					depth_q <= nd_q;
					if (!top_known_q) begin
						top_known_q <= 1'b1;
						state_q <= ST_TOP;
					end else begin
						// response top comes from the ram read of depth-1
						top_known_q <= 1'b0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: if (rsp.ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload capture and multiplier datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) cmd_q <= req.data.cmd;
		if (state_q == ST_RD1) e1_q <= rdata;
		if (state_q == ST_RD2) e2_q <= rdata;
		if (state_q == ST_RD3) e3_q <= rdata;
		// low product sums the registered partial products in the first multiply step
		if (state_q == ST_MUL && mstep_q == 2'd0)
			res_q <= pl_s1 + {pp1_s1 + pp2_s1, 32'd0};
		// 64x64 low product from three 32x32 partial products
		pl_s1 <= {32'd0, e2_q[31:0]} * {32'd0, e1_q[31:0]};
		pp1_s1 <= 32'(e2_q[63:32] * e1_q[31:0]);
		pp2_s1 <= 32'(e2_q[31:0] * e1_q[63:32]);
	end

	// the read in the prior cycle was of depth-1, with nd_q now committed
	logic [DataW-1:0] out_top;
	assign out_top = (depth_q == '0) ? '0 : (top_known_q && state_q == ST_OUT
		&& cmd_q != CMD_DROP && fault_q == FLT_NONE) ? top_q : rdata;
	logic [DataW-1:0] hold_q;
	logic hold_v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hold_v_q <= 1'b0;
		else hold_v_q <= (state_q == ST_OUT) && !rsp.ready;
	end
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && !hold_v_q) hold_q <= out_top;
	end

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = (state_q == ST_OUT);
	assign rsp.data.top_value = hold_v_q ? hold_q : out_top;
	assign rsp.data.stack_depth = 8'(depth_q);
	assign rsp.data.fault = fault_q;

	// depth never exceeds capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DepthW'(StackDepth))
		else $error("depth beyond capacity");
	// a faulting underflow or overflow leaves depth unchanged
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) && (fault_q == FLT_UNDER || fault_q == FLT_OVER)
		|-> depth_q == nd_q)
		else $error("faulted request changed depth");
	// no request taken while a response is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready)
		else $error("request accepted while busy");
endmodule

// ===== tb/stack_machine_alu_unit_tb.sv =====
// testbench for stack_machine_alu_unit: directed requests then random requests,
// each response checked against a stack predictor inside this module or a typed-in row
// depends on smalu_pkg, smalu_if and the rtl of the unit
`timescale 1ns / 100ps
module stack_machine_alu_unit_tb;
	import smalu_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	smalu_if #(.T(smalu_req_t)) req_ch ();
	smalu_if #(.T(smalu_rsp_t)) rsp_ch ();

	stack_machine_alu_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state: own copy of the stack
	logic [63:0] model_stack [0:StackDepth-1];
	int unsigned model_depth;

	smalu_rsp_t pending_rsp [$];
	int err_count = 0;
	int sender_idle = 0;
	int receiver_stall = 0;

	// directed row: expected response typed in only where check_fixed is set
	typedef struct {
		logic [4:0]  cmd;
		logic [63:0] lit;
		bit          check_fixed;
		smalu_rsp_t  fixed_rsp;
	} stim_row_t;

	function automatic logic [63:0] mag64(logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	// compute the response of one request and advance the predicted stack
	function automatic smalu_rsp_t stack_predict(logic [4:0] cmd, logic [63:0] lit);
		smalu_rsp_t r;
		int unsigned d;
		int unsigned need;
		int unsigned room;
		logic [1:0] flt;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] res;
		logic [63:0] q;
		bit do_push;
		d = model_depth;
		need = 0;
		room = 0;
		flt = FLT_NONE;
		res = '0;
		do_push = 1'b1;
		case (cmd)
			CMD_PUSH: room = 1;
			CMD_DROP, CMD_NOT: need = 1;
			CMD_DUP: begin need = 1; room = 1; end
			CMD_OVER: begin need = 2; room = 1; end
			CMD_ROT: need = 3;
			default: if (cmd >= CMD_SWAP && cmd <= CMD_XOR) need = 2;
		endcase
		if (d < need) flt = FLT_UNDER;
		else if (StackDepth - d < room) flt = FLT_OVER;
		else begin
			case (cmd)
				CMD_PUSH: begin model_stack[d] = lit; d++; end
				CMD_DROP: d--;
				CMD_DUP: begin model_stack[d] = model_stack[d-1]; d++; end
				CMD_SWAP: begin
					a = model_stack[d-1];
					model_stack[d-1] = model_stack[d-2];
					model_stack[d-2] = a;
				end
				CMD_OVER: begin model_stack[d] = model_stack[d-2]; d++; end
				CMD_ROT: begin
					a = model_stack[d-3];
					model_stack[d-3] = model_stack[d-2];
					model_stack[d-2] = model_stack[d-1];
					model_stack[d-1] = a;
				end
				CMD_NOT: model_stack[d-1] = (model_stack[d-1] == 0) ? 64'd1 : 64'd0;
				default: if (cmd >= CMD_ADD && cmd <= CMD_XOR) begin
					a = model_stack[d-2];
					b = model_stack[d-1];
					case (cmd)
						CMD_ADD: res = a + b;
						CMD_SUB: res = a - b;
						CMD_MUL: res = a * b;
						CMD_DIV, CMD_MOD: begin
							if (b == 0) begin
								do_push = 1'b0;
								flt = FLT_DIVZ;
							end else if (cmd == CMD_DIV) begin
								q = mag64(a) / mag64(b);
								res = (a[63] ^ b[63]) ? (64'd0 - q) : q;
							end else begin
								q = mag64(a) % mag64(b);
								res = a[63] ? (64'd0 - q) : q;
							end
						end
						CMD_EQ: res = (a == b);
						CMD_GT: res = ($signed(a) > $signed(b));
						CMD_LT: res = ($signed(b) > $signed(a));
						CMD_AND: res = (a != 0 && b != 0);
						CMD_OR: res = (a != 0 || b != 0);
						default: res = ((a != 0) != (b != 0));
					endcase
					d -= 2;
					if (do_push) begin model_stack[d] = res; d++; end
				end
			endcase
		end
		model_depth = d;
		r.top_value = (d > 0) ? model_stack[d-1] : 64'd0;
		r.stack_depth = d[7:0];
		r.fault = flt;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t mismatch %s: got %h want %h", $time, what, got, want);
		err_count++;
	endtask

	// send one request, recording its predicted response first;
	// valid stays high after acceptance until the next request or an idle gap
	task automatic send_request(logic [4:0] cmd, logic [63:0] lit);
		smalu_req_t q;
		q.cmd = cmd;
		q.literal = lit;
		if (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle);
		end
		pending_rsp.push_back(stack_predict(cmd, lit));
		req_ch.valid <= 1'b1;
		req_ch.data <= q;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	function automatic logic [63:0] rand_value();
		case ($urandom_range(7))
			0: return 64'h8000_0000_0000_0000;
			1: return 64'h7fff_ffff_ffff_ffff;
			2: return 64'd0;
			3: return 64'hffff_ffff_ffff_ffff;
			4: return 64'($urandom_range(9)) - 64'd4;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// receiver: random stall and compare against the oldest expectation
	always @(posedge clk) begin
		smalu_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected response", rsp_ch.data.top_value, 0);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_ch.data.top_value !== want.top_value)
					report_mismatch("top_value", rsp_ch.data.top_value, want.top_value);
				if (rsp_ch.data.stack_depth !== want.stack_depth)
					report_mismatch("stack_depth", rsp_ch.data.stack_depth, want.stack_depth);
				if (rsp_ch.data.fault !== want.fault)
					report_mismatch("fault", rsp_ch.data.fault, want.fault);
			end
		end
		rsp_ch.ready <= !(receiver_stall > 0 && $urandom_range(99) < receiver_stall);
	end

	// directed table: extremes, stack words and arithmetic, underflow and divide-by-zero faults
	function automatic stim_row_t row(logic [4:0] c, logic [63:0] l, bit chk = 0,
			logic [63:0] tv = 0, logic [7:0] sd = 0, logic [1:0] f = FLT_NONE);
		stim_row_t s;
		s.cmd = c;
		s.lit = l;
		s.check_fixed = chk;
		s.fixed_rsp.top_value = tv;
		s.fixed_rsp.stack_depth = sd;
		s.fixed_rsp.fault = f;
		return s;
	endfunction

	stim_row_t dir_table [$];

	task automatic run_phase(int n);
		int k;
		logic [4:0] c;
		for (k = 0; k < n; k++) begin
			// mostly valid commands, biased toward pushes to build depth
			case ($urandom_range(9))
				0, 1, 2: c = CMD_PUSH;
				3: c = 5'($urandom_range(31));
				default: c = 5'($urandom_range(CMD_NOT));
			endcase
			// keep the stack shallow mostly, sometimes drain it
			if (model_depth > 20 && $urandom_range(3) == 0) c = CMD_DROP;
			send_request(c, rand_value());
		end
	endtask

	initial begin
		int i;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		model_depth = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty stack: underflow on everything but push
		dir_table.push_back(row(CMD_DROP, 0, 1, 0, 0, FLT_UNDER));
		dir_table.push_back(row(CMD_NOT, 0, 1, 0, 0, FLT_UNDER));
		dir_table.push_back(row(CMD_PUSH, 64'h8000_0000_0000_0000, 1,
			64'h8000_0000_0000_0000, 1, FLT_NONE));
		dir_table.push_back(row(CMD_SWAP, 0, 1, 64'h8000_0000_0000_0000, 1, FLT_UNDER));
		dir_table.push_back(row(CMD_PUSH, 64'hffff_ffff_ffff_ffff, 1,
			64'hffff_ffff_ffff_ffff, 2, FLT_NONE));
		// most negative / -1 wraps to itself
		dir_table.push_back(row(CMD_ROT, 0, 1, 64'hffff_ffff_ffff_ffff, 2, FLT_UNDER));
		dir_table.push_back(row(CMD_OVER, 0));
		dir_table.push_back(row(CMD_OVER, 0));
		dir_table.push_back(row(CMD_DIV, 0));
		dir_table.push_back(row(CMD_ROT, 0));
		dir_table.push_back(row(CMD_MOD, 0));
		dir_table.push_back(row(CMD_PUSH, 64'h7fff_ffff_ffff_ffff));
		dir_table.push_back(row(CMD_DUP, 0));
		dir_table.push_back(row(CMD_ADD, 0));
		dir_table.push_back(row(CMD_PUSH, -64'sd7));
		dir_table.push_back(row(CMD_SUB, 0));
		dir_table.push_back(row(CMD_PUSH, 64'd0));
		dir_table.push_back(row(CMD_MOD, 0));
		dir_table.push_back(row(CMD_PUSH, 64'd3));
		dir_table.push_back(row(CMD_MUL, 0));
		foreach (dir_table[j]) begin
			send_request(dir_table[j].cmd, dir_table[j].lit);
			// fixed expectations replace the predicted ones where typed in
			if (dir_table[j].check_fixed)
				pending_rsp[pending_rsp.size()-1] = dir_table[j].fixed_rsp;
		end
		for (i = CMD_EQ; i <= CMD_NOT + 3; i++) begin
			send_request(CMD_PUSH, 64'(i - 12));
			send_request(5'(i), 0);
		end
		// fill to overflow, then drain
		while (model_depth < StackDepth) send_request(CMD_PUSH, rand_value());
		send_request(CMD_PUSH, 0);
		send_request(CMD_DUP, 0);
		send_request(CMD_OVER, 0);
		while (model_depth > 0) send_request(CMD_DROP, 0);

		run_phase(215);
		sender_idle = 86;
		run_phase(215);
		sender_idle = 0;
		receiver_stall = 86;
		run_phase(215);
		sender_idle = 38;
		receiver_stall = 38;
		run_phase(215);
		sender_idle = 0;
		receiver_stall = 0;
		req_ch.valid <= 1'b0;

		while (pending_rsp.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (err_count == 0)
			$display("stack_machine_alu_unit_tb: clean");
		else
			$display("stack_machine_alu_unit_tb: errors");
		$finish;
	end

	initial begin
		#20ms;
		$display("stack_machine_alu_unit_tb: errors");
		$finish;
	end
endmodule
